// ===== rtl/assert_macros.svh =====
// Assertion helpers; the enclosing module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication or plain expression.
`define SPNN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define SPNN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spnn_pkg.sv =====
package spnn_pkg;

	localparam int NOTE_REGS      = 8;
	localparam int NOTE_W         = 20;
	localparam int NOTE_IW        = 3;
	localparam int CFG_IW         = 4;
	localparam int BIN_W          = 24;
	localparam int IDX_W          = 9;
	localparam int FREQ_W         = 20;
	localparam int OFS_W          = 21;
	localparam int BINS_DEF       = 512;
	localparam int NOTE_COUNT_DEF = 8;

	// index * 44100 * 16 / 512 == index * 11025 / 8
	localparam int FREQ_MUL_W = 14;
	localparam logic [FREQ_MUL_W-1:0] FREQ_MUL = 14'd11025;
	localparam int FREQ_SHIFT = 3;
	localparam int PROD_W     = IDX_W + FREQ_MUL_W;

	typedef logic [NOTE_REGS-1:0][NOTE_W-1:0] note_tab_t;

	localparam note_tab_t NOTE_RESET = {
		20'd8372, 20'd7902, 20'd7040, 20'd6272,
		20'd5588, 20'd5274, 20'd4699, 20'd4186
	};

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] index;
	} frame_t;

endpackage

// ===== rtl/spnn_track.sv =====
`include "assert_macros.svh"

module spnn_track #(
	parameter int BINS = spnn_pkg::BINS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic signed [spnn_pkg::BIN_W-1:0] bin_real,
	input  logic                              last_bin,
	output spnn_pkg::frame_t                  frm
);
	import spnn_pkg::*;

	localparam int CAP_I = (BINS - 1 > (1 << IDX_W) - 1) ? (1 << IDX_W) - 1 : BINS - 1;
	localparam logic [IDX_W-1:0] CAP = IDX_W'(CAP_I);

	logic [IDX_W-1:0]        bin_count_q;
	logic signed [BIN_W-1:0] best_value_q;
	logic [IDX_W-1:0]        best_index_q;
	logic                    gt;
	logic [IDX_W-1:0]        idx_n;

	assign gt    = bin_real > best_value_q;
	assign idx_n = gt ? bin_count_q : best_index_q;

	assign frm.done  = accept & last_bin;
	assign frm.index = idx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q  <= '0;
			best_value_q <= '0;
			best_index_q <= '0;
		end else if (accept) begin
			if (last_bin) begin
				bin_count_q  <= '0;
				best_value_q <= '0;
				best_index_q <= '0;
			end else begin
				if (gt) begin
					best_value_q <= bin_real;
				end
				best_index_q <= idx_n;
				if (bin_count_q < CAP) begin
					bin_count_q <= bin_count_q + 1'b1;
				end
			end
		end
	end

	`SPNN_ASSERT(a_cnt_cap, bin_count_q <= CAP, "bin counter beyond cap")
	`SPNN_ASSERT_NEXT(a_frame_clr, frm.done, bin_count_q == '0 && best_value_q == '0, "frame not cleared")

endmodule

// ===== rtl/spnn_search.sv =====
`include "assert_macros.svh"

module spnn_search #(
	parameter int NOTE_COUNT = spnn_pkg::NOTE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spnn_pkg::frame_t                  frm,
	input  spnn_pkg::note_tab_t               notes,
	output logic                              idle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spnn_pkg::IDX_W-1:0]        peak_index,
	output logic [spnn_pkg::FREQ_W-1:0]       peak_freq,
	output logic [spnn_pkg::NOTE_W-1:0]       nearest_note,
	output logic signed [spnn_pkg::OFS_W-1:0] note_offset
);
	import spnn_pkg::*;

	localparam logic [NOTE_IW-1:0] LAST = NOTE_IW'(NOTE_COUNT - 1);
	localparam logic [NOTE_IW:0]   NCNT = (NOTE_IW + 1)'(NOTE_COUNT);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_LOW  = 4'd2;
	localparam logic [3:0] S_HIGH = 4'd3;
	localparam logic [3:0] S_MID  = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_NBL  = 4'd6;
	localparam logic [3:0] S_NBH  = 4'd7;
	localparam logic [3:0] S_PICK = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [FREQ_W-1:0]   t_q;
	logic [NOTE_W-1:0]   rd_q;
	logic [NOTE_W-1:0]   plo_q;
	logic [NOTE_W-1:0]   phi_q;
	logic [NOTE_W-1:0]   note_q;
	logic [NOTE_IW:0]    lo_q;
	logic [NOTE_IW:0]    hi_q;
	logic [NOTE_IW-1:0]  mid_q;
	logic                out_valid_q;
	logic [IDX_W-1:0]    o_idx_q;
	logic [FREQ_W-1:0]   o_freq_q;
	logic [NOTE_W-1:0]   o_note_q;

	logic [PROD_W-1:0]   prod;
	logic [NOTE_IW+1:0]  mid_sum;
	logic [NOTE_IW-1:0]  mid_n;
	logic [NOTE_IW-1:0]  rd_addr;
	logic [NOTE_W:0]     d_lo;
	logic [NOTE_W:0]     d_hi;
	logic                out_load;

	assign prod    = PROD_W'(idx_q) * PROD_W'(FREQ_MUL);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_n   = mid_sum[NOTE_IW:1];
	assign d_lo    = {1'b0, t_q} - {1'b0, plo_q};
	assign d_hi    = {1'b0, phi_q} - {1'b0, t_q};

	// single read port on the note table; data lands in rd_q for the next state
	always_comb begin
		case (state_q)
			S_LOW:   rd_addr = LAST;
			S_MID:   rd_addr = (lo_q >= hi_q) ? mid_q : mid_n;
			S_CMP:   rd_addr = (t_q < rd_q) ? mid_q - 1'b1 : mid_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		rd_q <= notes[rd_addr];
		if (state_q == S_IDLE && frm.done) begin
			idx_q <= frm.index;
		end
		if (state_q == S_MUL) begin
			t_q <= prod[PROD_W-1:FREQ_SHIFT];
		end
		if (out_load) begin
			o_idx_q  <= idx_q;
			o_freq_q <= t_q;
			o_note_q <= note_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			plo_q       <= '0;
			phi_q       <= '0;
			note_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (frm.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_LOW;
				end
				S_LOW: begin
					if (t_q <= rd_q) begin
						note_q  <= rd_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_HIGH;
					end
				end
				S_HIGH: begin
					if (t_q >= rd_q) begin
						note_q  <= rd_q;
						state_q <= S_DONE;
					end else begin
						lo_q    <= '0;
						hi_q    <= NCNT;
						mid_q   <= '0;
						state_q <= S_MID;
					end
				end
				S_MID: begin
					if (lo_q >= hi_q) begin
						state_q <= S_FIN;
					end else begin
						mid_q   <= mid_n;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_q == t_q) begin
						note_q  <= t_q;
						state_q <= S_DONE;
					end else if (t_q < rd_q) begin
						phi_q <= rd_q;
						if (mid_q != '0) begin
							state_q <= S_NBL;
						end else begin
							hi_q    <= {1'b0, mid_q};
							state_q <= S_MID;
						end
					end else begin
						plo_q <= rd_q;
						if (mid_q < LAST) begin
							state_q <= S_NBH;
						end else begin
							lo_q    <= {1'b0, mid_q} + 1'b1;
							state_q <= S_MID;
						end
					end
				end
				S_NBL: begin
					if (t_q > rd_q) begin
						plo_q   <= rd_q;
						state_q <= S_PICK;
					end else begin
						hi_q    <= {1'b0, mid_q};
						state_q <= S_MID;
					end
				end
				S_NBH: begin
					if (t_q < rd_q) begin
						phi_q   <= rd_q;
						state_q <= S_PICK;
					end else begin
						lo_q    <= {1'b0, mid_q} + 1'b1;
						state_q <= S_MID;
					end
				end
				S_PICK: begin
					// tie goes to the upper note
					note_q  <= (d_lo >= d_hi) ? phi_q : plo_q;
					state_q <= S_DONE;
				end
				S_FIN: begin
					note_q  <= rd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle         = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign peak_index   = o_idx_q;
	assign peak_freq    = o_freq_q;
	assign nearest_note = o_note_q;
	assign note_offset  = $signed({1'b0, o_note_q} - {1'b0, o_freq_q});

	`SPNN_ASSERT(a_busy_no_start, (state_q != S_IDLE) |-> !frm.done, "frame end taken while busy")
	`SPNN_ASSERT_NEXT(a_pick_done, state_q == S_PICK, state_q == S_DONE, "pick did not finish")
	`SPNN_ASSERT(a_rose_done, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result from wrong state")
	`SPNN_ASSERT(a_bounds, (state_q == S_MID) |-> (hi_q <= NCNT && lo_q <= NCNT), "search bounds out of range")

endmodule

// ===== rtl/spectral_peak_nearest_note_top.sv =====
// Spectral peak picker with nearest-note lookup.
// Input channel (in_valid/in_ready): one spectrum bin per transaction, bin_real
// signed, last_bin high on the final bin of a frame. Bins that are not last
// are taken at one per cycle; the block tracks the first largest bin above zero.
// On the last bin the peak index becomes a Q4 frequency (index*11025/8) and a
// binary search over NOTE_COUNT configured notes picks the closest one.
// Output channel (out_valid/out_ready): one transaction per frame with
// peak_index, peak_freq, nearest_note and note_offset (note minus peak).
// After the last bin the search forms the frequency, then checks the first
// note and then the last used note, ending there when the peak is at or below
// the first or at or above the last; otherwise binary search steps follow, each
// on the single note-table read port. in_ready is low from the last bin until
// the result is in the output register, so a frame costs its bins plus the
// search time.
// A stalled receiver holds the result in the output register; the next
// frame's bins still stream in, but after its last bin the search holds in
// its final state, with in_ready low, until the previous result is taken.
// Reset clears the frame state and output valid and loads the default notes.
// cfg_we writes note register cfg_addr (0..7); other indices are ignored.
module spectral_peak_nearest_note_top #(
	parameter int BINS       = spnn_pkg::BINS_DEF,
	parameter int NOTE_COUNT = spnn_pkg::NOTE_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [spnn_pkg::CFG_IW-1:0]        cfg_addr,
	input  logic [spnn_pkg::NOTE_W-1:0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [spnn_pkg::BIN_W-1:0]  bin_real,
	input  logic                               last_bin,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spnn_pkg::IDX_W-1:0]         peak_index,
	output logic [spnn_pkg::FREQ_W-1:0]        peak_freq,
	output logic [spnn_pkg::NOTE_W-1:0]        nearest_note,
	output logic signed [spnn_pkg::OFS_W-1:0]  note_offset
);
	import spnn_pkg::*;

	note_tab_t notes_q;
	frame_t    frm;
	logic      accept;
	logic      idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notes_q <= NOTE_RESET;
		end else if (cfg_we && cfg_addr < CFG_IW'(NOTE_REGS)) begin
			notes_q[cfg_addr[NOTE_IW-1:0]] <= cfg_wdata;
		end
	end

	assign in_ready = idle;
	assign accept   = in_valid & in_ready;

	spnn_track #(
		.BINS(BINS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.bin_real (bin_real),
		.last_bin (last_bin),
		.frm      (frm)
	);

	spnn_search #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.frm          (frm),
		.notes        (notes_q),
		.idle         (idle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.peak_index   (peak_index),
		.peak_freq    (peak_freq),
		.nearest_note (nearest_note),
		.note_offset  (note_offset)
	);

endmodule
